// ===== rtl/bbf_pkg.sv =====
// ----------------------------------------------------------------------------
// bbf_pkg
// shared types and constants of the blocked bloom filter
// ----------------------------------------------------------------------------
package bbf_pkg;

   // item opcodes; the fourth code is unused and dropped
   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2,
      OP_RSVD  = 2'd3
   } bbf_op_type;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_BLOCK_COUNT = 1'b0,
      CSR_HASH_COUNT  = 1'b1
   } bbf_csr_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_MIX,
      FR_DIV,
      FR_PUSH
   } bbf_front_state_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_READ,
      BK_CHECK,
      BK_RESULT
   } bbf_back_state_type;

   // status from the probe engine to the hash front
   typedef struct packed {
      logic init_busy;
      logic clearing;
   } bbf_status_type;

   localparam int          KEY_BYTES = 33;
   localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
   localparam logic [63:0] SEED      = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MASK_A    = 64'ha5a5a5a55a5a5a5a;
   localparam logic [63:0] MASK_B    = 64'h5a5a5a5aa5a5a5a5;

   // xor-shift step of the finalizer
   function automatic logic [63:0] xor_shift(input logic [63:0] x);
      return x ^ (x >> 33);
   endfunction

endpackage

// ===== rtl/bbf_queue.sv =====
// ----------------------------------------------------------------------------
// bbf_queue
// two-entry queue between the hash front and the probe engine
// ----------------------------------------------------------------------------
module bbf_queue #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ===== rtl/bbf_front.sv =====
// ----------------------------------------------------------------------------
// bbf_front
// accepts items, hashes the key with a shared 32x32 multiplier and picks the
// block with a bit-serial remainder unit
// ----------------------------------------------------------------------------
module bbf_front #(
   parameter  int MAX_BLOCKS = 64,
   parameter  int BLOCK_BITS = 16384,
   localparam int BCW        = $clog2(MAX_BLOCKS + 1),
   localparam int BLK_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
   localparam int POS_W      = $clog2(BLOCK_BITS),
   localparam int ENTRY_W    = 2 + BLK_W + 2 * POS_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_opcode,
   input  logic [63:0]            req_key_word0,
   input  logic [63:0]            req_key_word1,
   input  logic [63:0]            req_key_word2,
   input  logic [63:0]            req_key_word3,
   input  logic [7:0]             req_key_last_byte,
   input  logic [BCW-1:0]         blocks,
   input  bbf_pkg::bbf_status_type status,
   output logic                   push_valid,
   output logic [ENTRY_W-1:0]     push_data,
   input  logic                   queue_full
);
   import bbf_pkg::*;

   bbf_front_state_type state_ff, state_in;
   bbf_op_type          op_ff, op_in;
   logic [8*KEY_BYTES-1:0] key_ff, key_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  step_ff, step_in;
   logic [63:0] v_ff, v_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] ha_ff, ha_in;
   logic [63:0] hb_ff, hb_in;
   logic [31:0] dq_ff, dq_in;
   logic [BCW-1:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [63:0] mix_c;
   logic [63:0] mix_out;
   logic [5:0]  round_nxt;
   logic [7:0]  key_byte;
   logic [BCW:0] trial;
   logic        accept;

   assign req_stall = (state_ff != FR_IDLE) || status.init_busy;
   assign accept    = req_valid && !req_stall;

   // shared multiplier: three partial products per 64-bit constant multiply
   assign mix_c = step_ff[2] ? MIX_C2 : MIX_C1;
   always_comb begin
      mul_a = v_ff[31:0];
      mul_b = mix_c[31:0];
      case (step_ff[1:0])
         2'd1:    mul_a = v_ff[63:32];
         2'd2:    mul_b = mix_c[63:32];
         default: mul_a = v_ff[31:0];
      endcase
   end
   assign prod = mul_a * mul_b;

   // byte folded in at the start of the next round
   assign mix_out   = xor_shift(acc_ff);
   assign round_nxt = round_ff + 6'd1;
   assign key_byte  = key_ff[{round_nxt, 3'b000} +: 8];
   assign trial     = {rem_ff, dq_ff[31]};

   assign push_valid = (state_ff == FR_PUSH);
   assign push_data  = {op_ff, BLK_W'(rem_ff), ha_ff[POS_W-1:0], hb_ff[POS_W-1:0]};

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      round_in = round_ff;
      step_in  = step_ff;
      v_in     = v_ff;
      acc_in   = acc_ff;
      h_in     = h_ff;
      ha_in    = ha_ff;
      hb_in    = hb_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         FR_IDLE: begin
            if (accept) begin
               op_in    = bbf_op_type'(req_opcode);
               key_in   = {req_key_last_byte, req_key_word3, req_key_word2,
                           req_key_word1, req_key_word0};
               round_in = 6'd0;
               step_in  = 3'd0;
               v_in     = xor_shift(SEED ^ {56'd0, req_key_word0[7:0]});
               case (req_opcode)
                  OP_ADD, OP_QUERY: state_in = FR_MIX;
                  OP_CLEAR:         state_in = FR_PUSH;
                  default:          state_in = FR_IDLE;
               endcase
            end
         end
         FR_MIX: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0, 3'd4: acc_in = prod;
               3'd1, 3'd2, 3'd5, 3'd6: acc_in = acc_ff + {prod[31:0], 32'd0};
               3'd3:       v_in   = mix_out;
               default: begin
                  // end of one finalizer pass
                  round_in = round_nxt;
                  if (round_ff < 6'd32) begin
                     v_in = xor_shift(mix_out ^
                            ({56'd0, key_byte} << {round_nxt[2:0], 3'b000}));
                  end else if (round_ff == 6'd32) begin
                     h_in = mix_out;
                     v_in = xor_shift(mix_out ^ MASK_A);
                  end else if (round_ff == 6'd33) begin
                     ha_in = mix_out;
                     v_in  = xor_shift(h_ff ^ MASK_B);
                  end else begin
                     hb_in    = mix_out | 64'd1;
                     dq_in    = ha_ff[63:32];
                     rem_in   = '0;
                     cnt_in   = 5'd0;
                     state_in = FR_DIV;
                  end
               end
            endcase
         end
         FR_DIV: begin
            // one quotient bit a cycle, remainder only
            dq_in  = {dq_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (trial >= {1'b0, blocks}) begin
               rem_in = BCW'(trial - {1'b0, blocks});
            end else begin
               rem_in = BCW'(trial);
            end
            if (cnt_ff == 5'd31) begin
               state_in = FR_PUSH;
            end
         end
         FR_PUSH: begin
            if (!queue_full) begin
               state_in = FR_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      key_ff   <= key_in;
      round_ff <= round_in;
      step_ff  <= step_in;
      v_ff     <= v_in;
      acc_ff   <= acc_in;
      h_ff     <= h_in;
      ha_ff    <= ha_in;
      hb_ff    <= hb_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end
endmodule

// ===== rtl/bbf_back.sv =====
// ----------------------------------------------------------------------------
// bbf_back
// probe engine: owns the bit store, sets or tests one bit per probe and runs
// the clearing sweep
// ----------------------------------------------------------------------------
module bbf_back #(
   parameter  int MAX_BLOCKS = 64,
   parameter  int BLOCK_BITS = 16384,
   parameter  int MAX_HASHES = 32,
   localparam int HW         = $clog2(MAX_HASHES + 1),
   localparam int PCW        = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1,
   localparam int BLK_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
   localparam int POS_W      = $clog2(BLOCK_BITS),
   localparam int ENTRY_W    = 2 + BLK_W + 2 * POS_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [HW-1:0]          probes,
   input  logic                   queue_empty,
   input  logic [ENTRY_W-1:0]     queue_data,
   output logic                   queue_pop,
   output bbf_pkg::bbf_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_maybe_present
);
   import bbf_pkg::*;

   localparam int DEPTH  = MAX_BLOCKS * (BLOCK_BITS / 64);
   localparam int ADDR_W = $clog2(DEPTH);

   logic [63:0] mem [DEPTH];

   bbf_back_state_type state_ff, state_in;
   bbf_op_type      op_ff, op_in;
   logic [BLK_W-1:0] block_ff, block_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] stride_ff, stride_in;
   logic [PCW-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic            init_done_ff, init_done_in;
   logic            result_ff, result_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            present_ff, present_in;
   logic [63:0]     rdata_ff;

   logic [ADDR_W-1:0] probe_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [63:0]       wr_data;
   logic              wr_en;
   logic              bit_set;
   logic              last_probe;
   logic              out_free;

   assign probe_addr = ADDR_W'({block_ff, pos_ff[POS_W-1:6]});
   assign bit_set    = rdata_ff[pos_ff[5:0]];
   assign last_probe = (HW'(cnt_ff) + HW'(1)) == probes;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign status.init_busy = !init_done_ff;
   assign status.clearing  = (state_ff == BK_CLEAR);
   assign queue_pop        = (state_ff == BK_IDLE) && !queue_empty;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_maybe_present = present_ff;

   // probe sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      block_in     = block_ff;
      pos_in       = pos_ff;
      stride_in    = stride_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      init_done_in = init_done_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      present_in   = present_ff;
      wr_en        = 1'b0;
      wr_addr      = probe_addr;
      wr_data      = rdata_ff | (64'd1 << pos_ff[5:0]);
      unique case (state_ff)
         BK_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               init_done_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!queue_empty) begin
               op_in     = bbf_op_type'(queue_data[ENTRY_W-1 -: 2]);
               block_in  = queue_data[2*POS_W +: BLK_W];
               pos_in    = queue_data[POS_W +: POS_W];
               stride_in = queue_data[0 +: POS_W];
               cnt_in    = '0;
               clr_in    = '0;
               if (bbf_op_type'(queue_data[ENTRY_W-1 -: 2]) == OP_CLEAR) begin
                  state_in = BK_CLEAR;
               end else begin
                  state_in = BK_READ;
               end
            end
         end
         BK_READ: begin
            state_in = BK_CHECK;
         end
         BK_CHECK: begin
            pos_in = pos_ff + stride_ff;
            cnt_in = cnt_ff + PCW'(1);
            if (op_ff == OP_ADD) begin
               wr_en = 1'b1;
               state_in = last_probe ? BK_IDLE : BK_READ;
            end else if (!bit_set || last_probe) begin
               result_in = bit_set;
               state_in  = BK_RESULT;
            end else begin
               state_in = BK_READ;
            end
         end
         BK_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               present_in   = result_ff;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         init_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         init_done_ff <= init_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      block_ff   <= block_in;
      pos_ff     <= pos_in;
      stride_ff  <= stride_in;
      cnt_ff     <= cnt_in;
      result_ff  <= result_in;
      present_ff <= present_in;
   end

   // bit store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[probe_addr];
   end
endmodule

// ===== rtl/blocked_bloom_filter.sv =====
// add or query: key hashing, block selection and the queue, then a read and a
//   check state per probe (up to hash_count probes) for the read-modify-write
//   on the single bit store; a query result follows
// clear: one bit store word per cycle, over all MAX_BLOCKS*BLOCK_BITS/64 words
// a new item is taken once the previous one is pushed to the queue
// reset: clearing sweep of all MAX_BLOCKS*BLOCK_BITS/64 words, req_stall high
// ----------------------------------------------------------------------------
// blocked_bloom_filter
// top level: configuration registers, hash front, queue and probe engine
// ----------------------------------------------------------------------------
module blocked_bloom_filter #(
   parameter int MAX_BLOCKS = 64,
   parameter int BLOCK_BITS = 16384,
   parameter int MAX_HASHES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [63:0] req_key_word0,
   input  logic [63:0] req_key_word1,
   input  logic [63:0] req_key_word2,
   input  logic [63:0] req_key_word3,
   input  logic [7:0]  req_key_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_maybe_present,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [6:0]  csr_wdata
);
   import bbf_pkg::*;

   localparam int BCW     = $clog2(MAX_BLOCKS + 1);
   localparam int HW      = $clog2(MAX_HASHES + 1);
   localparam int BLK_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int POS_W   = $clog2(BLOCK_BITS);
   localparam int ENTRY_W = 2 + BLK_W + 2 * POS_W;

   logic [6:0] block_count_ff, block_count_in;
   logic [5:0] hash_count_ff, hash_count_in;
   logic [BCW-1:0] blocks;
   logic [HW-1:0]  probes;

   bbf_status_type     status;
   logic               push_valid;
   logic [ENTRY_W-1:0] push_data;
   logic               queue_full;
   logic               queue_pop;
   logic [ENTRY_W-1:0] queue_data;
   logic               queue_empty;

   assign csr_ready = 1'b1;

   // configuration registers
   always_comb begin
      block_count_in = block_count_ff;
      hash_count_in  = hash_count_ff;
      if (csr_valid) begin
         unique case (bbf_csr_type'(csr_index))
            CSR_BLOCK_COUNT: block_count_in = csr_wdata;
            CSR_HASH_COUNT:  hash_count_in  = csr_wdata[5:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= 7'd1;
         hash_count_ff  <= 6'd1;
      end else begin
         block_count_ff <= block_count_in;
         hash_count_ff  <= hash_count_in;
      end
   end

   // zero counts act as one, large counts saturate
   always_comb begin
      if (block_count_ff == 7'd0) begin
         blocks = BCW'(1);
      end else if (32'(block_count_ff) > MAX_BLOCKS) begin
         blocks = BCW'(MAX_BLOCKS);
      end else begin
         blocks = BCW'(block_count_ff);
      end
      if (hash_count_ff == 6'd0) begin
         probes = HW'(1);
      end else if (32'(hash_count_ff) > MAX_HASHES) begin
         probes = HW'(MAX_HASHES);
      end else begin
         probes = HW'(hash_count_ff);
      end
   end

   bbf_front #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .BLOCK_BITS (BLOCK_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_key_word0     (req_key_word0),
      .req_key_word1     (req_key_word1),
      .req_key_word2     (req_key_word2),
      .req_key_word3     (req_key_word3),
      .req_key_last_byte (req_key_last_byte),
      .blocks            (blocks),
      .status            (status),
      .push_valid        (push_valid),
      .push_data         (push_data),
      .queue_full        (queue_full)
   );

   bbf_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_data   (queue_data),
      .empty      (queue_empty)
   );

   bbf_back #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .BLOCK_BITS (BLOCK_BITS),
      .MAX_HASHES (MAX_HASHES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .probes            (probes),
      .queue_empty       (queue_empty),
      .queue_data        (queue_data),
      .queue_pop         (queue_pop),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_maybe_present (rsp_maybe_present)
   );
endmodule

// ===== rtl/bbf_checker.sv =====
// ----------------------------------------------------------------------------
// bbf_checker
// port-level checks of the blocked bloom filter
// ----------------------------------------------------------------------------
module bbf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_opcode,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_maybe_present,
   input logic        csr_valid,
   input logic        csr_ready
);
   import bbf_pkg::*;

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_maybe_present))
      else $error("result beat changed while stalled");

   // the clearing sweep after reset blocks new items
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("item taken during reset clearing");

   // an accepted add or query keeps the hash front busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == OP_ADD || req_opcode == OP_QUERY)
      |=> req_stall)
      else $error("hash front took back-to-back keys");

   // configuration port never refuses a write
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write refused");
endmodule

bind blocked_bloom_filter bbf_checker u_bbf_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_opcode        (req_opcode),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_maybe_present (rsp_maybe_present),
   .csr_valid         (csr_valid),
   .csr_ready         (csr_ready)
);
